### sv/swts_pkg.sv
// Shared types, constants and character helpers for the text search unit.
// No dependencies; imported by every other file of the block.
`default_nettype none

package swts_pkg;

   localparam int MAX_TARGET   = 16;
   localparam int CHAR_W       = 16;
   localparam int TLEN_W       = 5;
   localparam int IDX_W        = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int REG_CHARS    = 16;

   localparam logic [CHAR_W-1:0] NBSP_CHAR    = 16'h00A0;
   localparam logic [CHAR_W-1:0] SPACE_CHAR   = 16'h0020;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 16'h000A;
   localparam logic [CHAR_W-1:0] FOLD_OFFSET  = 16'h0020;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MID_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MID_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HIGH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LENGTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CASE_SENSITIVE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_LAST       = 3'd6;

   typedef struct packed {
      logic shift;
      logic clear;
      logic kill;
      logic active;
   } cell_ctl_type;

   // Latin-1 lower-case fold plus NBSP to space
   function automatic logic [CHAR_W-1:0] normalize(input logic [CHAR_W-1:0] c,
                                                   input logic case_sens);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c == NBSP_CHAR) begin
         r = SPACE_CHAR;
      end else if (!case_sens) begin
         if (c inside {[16'h0041:16'h005A]}) begin
            r = c + FOLD_OFFSET;
         end else if ((c inside {[16'h00C0:16'h00DE]}) && (c != 16'h00D7)) begin
            r = c + FOLD_OFFSET;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/swts_if.sv
// Valid/ready channel interfaces for request, response and register write.
// Depends on swts_pkg for field widths.
`default_nettype none

interface swts_req_if import swts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_char;
   logic              break_before;
   logic              end_of_text;

   modport source (output valid, text_char, break_before, end_of_text, input ready);
   modport sink   (input valid, text_char, break_before, end_of_text, output ready);
endinterface

interface swts_rsp_if import swts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             match_here;
   logic             found;
   logic [IDX_W-1:0] match_start;
   logic             done_res;

   modport source (output valid, match_here, found, match_start, done_res, input ready);
   modport sink   (input valid, match_here, found, match_start, done_res, output ready);
endinterface

interface swts_csr_if import swts_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/swts_cell.sv
// One window cell: holds a character and its fill bit, compares its next value.
// Depends on swts_pkg.
`default_nettype none

module swts_cell
   import swts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cell_ctl_type      ctl,
   input  wire logic [CHAR_W-1:0] data_i,
   input  wire logic              valid_i,
   input  wire logic [CHAR_W-1:0] target_char,
   output      logic [CHAR_W-1:0] data_o,
   output      logic              valid_o,
   output      logic              match_ok
);

   logic [CHAR_W-1:0] data_ff;
   logic              valid_ff;
   logic              valid_in;

   assign valid_in = valid_i & ~ctl.kill;
   assign match_ok = ~ctl.active | (valid_in & (data_i == target_char));
   assign data_o   = data_ff;
   assign valid_o  = valid_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         data_ff <= data_i;
      end
   end

endmodule

`default_nettype wire

### sv/sliding_window_text_search_unit.sv
// Sliding-window text search: one character per transfer enters a row of
// MAX_TARGET cells; the window is compared against the normalized target as
// it shifts; every request yields one response from an output register in
// the cycle after it is taken. A new request is taken every cycle while the
// response side keeps up, as the cell row compares in parallel. The user must
// write registers only while the block is idle; the block does not enforce it.
// Depends on swts_pkg, swts_if and swts_cell.
`default_nettype none

module sliding_window_text_search_unit
   import swts_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   swts_req_if.sink   req_bus,
   swts_rsp_if.source rsp_bus,
   swts_csr_if.sink   csr_bus
);

   logic [CSR_DATA_W-1:0] target_ff [4];
   logic [TLEN_W-1:0]     tlen_ff;
   logic                  case_ff;
   logic                  keep_last_ff;

   logic [IDX_W-1:0] char_index_ff;
   logic             found_ff;
   logic [IDX_W-1:0] kept_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             match_ff, rsp_found_ff, done_ff;
   logic [IDX_W-1:0] start_ff;

   logic              req_fire;
   logic              shift_en;
   logic [CHAR_W-1:0] tchar [REG_CHARS];
   logic              newline_hit;
   logic              len_ok;
   logic              hit, take;
   logic              found_in;
   logic [IDX_W-1:0]  kept_in;

   logic [CHAR_W-1:0] cell_data  [MAX_TARGET];
   logic              cell_valid [MAX_TARGET];
   logic [MAX_TARGET-1:0] cell_ok;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            target_ff[i] <= '0;
         end
         tlen_ff      <= '0;
         case_ff      <= 1'b0;
         keep_last_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_TARGET_LOW:      target_ff[0] <= csr_bus.data;
            CSR_TARGET_MID_LOW:  target_ff[1] <= csr_bus.data;
            CSR_TARGET_MID_HIGH: target_ff[2] <= csr_bus.data;
            CSR_TARGET_HIGH:     target_ff[3] <= csr_bus.data;
            CSR_TARGET_LENGTH:   tlen_ff      <= csr_bus.data[TLEN_W-1:0];
            CSR_CASE_SENSITIVE:  case_ff      <= csr_bus.data[0];
            CSR_KEEP_LAST:       keep_last_ff <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < REG_CHARS; j++) begin
         tchar[j] = target_ff[j / 4][(j % 4) * CHAR_W +: CHAR_W];
      end
   end

   always_comb begin
      newline_hit = 1'b0;
      for (int j = 0; j < REG_CHARS; j++) begin
         if ((TLEN_W'(j) < tlen_ff) && (tchar[j] == NEWLINE_CHAR)) begin
            newline_hit = 1'b1;
         end
      end
   end

   assign len_ok = (tlen_ff != '0) && (32'(tlen_ff) <= 32'(MAX_TARGET));

   assign req_bus.ready = ~rsp_valid_ff | rsp_bus.ready;
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign shift_en      = req_fire & ~req_bus.end_of_text;

   for (genvar k = 0; k < MAX_TARGET; k++) begin : g_cell
      cell_ctl_type      ctl;
      logic [TLEN_W-1:0] tidx;
      logic [CHAR_W-1:0] raw;
      logic [CHAR_W-1:0] din;
      logic              vin;

      assign tidx = tlen_ff - TLEN_W'(1) - TLEN_W'(k);
      assign raw  = (32'(tidx) < REG_CHARS) ? tchar[tidx[3:0]] : '0;

      assign ctl.shift  = shift_en;
      assign ctl.clear  = req_fire & req_bus.end_of_text;
      assign ctl.kill   = (k != 0) && req_bus.break_before;
      assign ctl.active = 32'(tlen_ff) > k;

      if (k == 0) begin : g_head
         assign din = normalize(req_bus.text_char, case_ff);
         assign vin = 1'b1;
      end else begin : g_body
         assign din = cell_data[k-1];
         assign vin = cell_valid[k-1];
      end

      swts_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .data_i      (din),
         .valid_i     (vin),
         .target_char (normalize(raw, case_ff)),
         .data_o      (cell_data[k]),
         .valid_o     (cell_valid[k]),
         .match_ok    (cell_ok[k])
      );
   end

   assign hit      = len_ok & ~newline_hit & (&cell_ok);
   assign take     = hit & (keep_last_ff | ~found_ff);
   assign found_in = found_ff | take;
   assign kept_in  = take ? (char_index_ff + IDX_W'(1) - IDX_W'(tlen_ff)) : kept_ff;

   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_bus.end_of_text)) begin
         char_index_ff <= '0;
         found_ff      <= 1'b0;
         kept_ff       <= '0;
      end else if (shift_en) begin
         char_index_ff <= char_index_ff + IDX_W'(1);
         found_ff      <= found_in;
         kept_ff       <= kept_in;
      end
   end

   assign rsp_valid_in = req_fire | (rsp_valid_ff & ~rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (req_bus.end_of_text) begin
            match_ff     <= 1'b0;
            rsp_found_ff <= found_ff;
            start_ff     <= kept_ff;
            done_ff      <= 1'b1;
         end else begin
            match_ff     <= hit;
            rsp_found_ff <= found_in;
            start_ff     <= kept_in;
            done_ff      <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.match_here  = match_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.match_start = start_ff;
   assign rsp_bus.done_res    = done_ff;

endmodule

`default_nettype wire

### sv/swts_checker.sv
// Port-level assertions for the text search unit, attached by bind.
// Depends on swts_pkg and the top level's channel interfaces.
`default_nettype none

module swts_checker
   import swts_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             req_end,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_match,
   input wire logic             rsp_found,
   input wire logic [IDX_W-1:0] rsp_start,
   input wire logic             rsp_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start) && $stable(rsp_done))
      else $error("stalled response changed");

   a_end_done: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end |=> rsp_valid && rsp_done && !rsp_match)
      else $error("end of text transfer did not give a done response");

   a_match_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match |-> rsp_found)
      else $error("match reported without found");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_start == '0)
      else $error("match start nonzero before any match");

endmodule

bind sliding_window_text_search_unit swts_checker u_swts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_end   (req_bus.end_of_text),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_match (rsp_bus.match_here),
   .rsp_found (rsp_bus.found),
   .rsp_start (rsp_bus.match_start),
   .rsp_done  (rsp_bus.done_res)
);

`default_nettype wire
